// ===== rtl/dweo_pkg.sv =====
// Shared constants, register indexes and sequencer states for the wheel odometry block.
`timescale 1ns / 1ps

package dweo_pkg;

  // Default widths of the encoder counters, the running totals and the timestamp.
  localparam int COUNTER_BITS_DEF = 16;
  localparam int TOTAL_BITS_DEF   = 48;
  localparam int TIME_BITS_DEF    = 32;

  // Fixed widths of the scale registers and of the result fields.
  localparam int SCALE_W     = 20;
  localparam int DIST_W      = 36;
  localparam int TOTAL_OUT_W = 48;
  localparam int CFG_IDX_W   = 1;

  // Scale values after reset, in nanometres per count.
  localparam logic [SCALE_W-1:0] LEFT_SCALE_RST  = SCALE_W'(52300);
  localparam logic [SCALE_W-1:0] RIGHT_SCALE_RST = SCALE_W'(47070);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE = 1'b1;

  // Wheel selector values.
  localparam logic WHEEL_LEFT  = 1'b0;
  localparam logic WHEEL_RIGHT = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_TOT,
    ST_DIV,
    ST_DONE
  } dweo_state_t;

endpackage

// ===== rtl/dual_wheel_encoder_odometry_unit.sv =====
// Top level of the dual wheel encoder odometry unit with its shared arithmetic sequencer.
`timescale 1ns / 1ps

// Dual wheel encoder odometry unit.
// Input channel (in_valid / in_stall): one item is a sample of both wheel counters
// and a microsecond timestamp. Output channel (out_valid / out_stall): one item per
// input item carrying per-wheel distance, speed and running total, the period and a
// zero-period flag. The scale registers are written through cfg_wr_en, cfg_index and
// cfg_data, and only while the block is idle: a rule for the user that the block
// itself does not enforce. An item with a non-zero period is worked through per wheel
// as one multiply, one saturation, one total update and 36 restoring division steps
// through a single shared subtractor; then a hand-over state loads the result into the
// output register and an idle state comes before the next acceptance. With a zero
// period the divisions are skipped. in_stall is high while an item is being worked on.
// A stalled result is held in the output register; the next item is accepted and
// processed meanwhile, and waits at its end until the output register is free.
// Reset clears the previous counters, timestamp and totals to zero, loads the
// default scales and empties the output register.
module dual_wheel_encoder_odometry_unit #(
  parameter int COUNTER_BITS = dweo_pkg::COUNTER_BITS_DEF,
  parameter int TOTAL_BITS   = dweo_pkg::TOTAL_BITS_DEF,
  parameter int TIME_BITS    = dweo_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [dweo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dweo_pkg::SCALE_W-1:0]         cfg_data,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [COUNTER_BITS-1:0]              left_count,
  input  logic [COUNTER_BITS-1:0]              right_count,
  input  logic [TIME_BITS-1:0]                 timestamp_us,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dweo_pkg::DIST_W-1:0]   left_distance_nm,
  output logic signed [dweo_pkg::DIST_W-1:0]   right_distance_nm,
  output logic signed [dweo_pkg::DIST_W-1:0]   left_speed_mm_s,
  output logic signed [dweo_pkg::DIST_W-1:0]   right_speed_mm_s,
  output logic signed [dweo_pkg::TOTAL_OUT_W-1:0] left_total_nm,
  output logic signed [dweo_pkg::TOTAL_OUT_W-1:0] right_total_nm,
  output logic [TIME_BITS-1:0]                 period_us,
  output logic                                 period_zero
);

  import dweo_pkg::*;

  // Product width: signed delta times unsigned scale, at least one bit over the distance.
  localparam int PROD_RAW = COUNTER_BITS + SCALE_W + 1;
  localparam int PROD_W   = (PROD_RAW > DIST_W) ? PROD_RAW : DIST_W + 1;
  localparam int CNT_W    = $clog2(DIST_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIST_W - 1);

  // Saturation limits.
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic signed [TOTAL_BITS-1:0] TOT_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] TOT_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  dweo_state_t state, state_next;

  // Configuration and history registers.
  logic [SCALE_W-1:0]             left_scale;
  logic [SCALE_W-1:0]             right_scale;
  logic [COUNTER_BITS-1:0]        prev_left;
  logic [COUNTER_BITS-1:0]        prev_right;
  logic [TIME_BITS-1:0]           prev_time;
  logic signed [TOTAL_BITS-1:0]   total [2];

  // Working registers of the current item.
  logic signed [COUNTER_BITS-1:0] delta [2];
  logic signed [DIST_W-1:0]       distance [2];
  logic signed [DIST_W-1:0]       speed [2];
  logic [TIME_BITS-1:0]           period;
  logic                           pz;
  logic                           wheel;
  logic signed [PROD_W-1:0]       prod;
  logic [DIST_W-1:0]              quo;
  logic [TIME_BITS-1:0]           rem;
  logic                           div_neg;
  logic [CNT_W-1:0]               cnt;

  // Control decoded from the state.
  logic in_take;
  logic out_load;
  logic wheel_end;
  logic div_last;

  // Datapath signals.
  logic signed [COUNTER_BITS-1:0] mul_a;
  logic [SCALE_W-1:0]             mul_b;
  logic signed [PROD_W-1:0]       prod_full;
  logic                           prod_ones;
  logic                           prod_zeros;
  logic signed [DIST_W-1:0]       dist_cur;
  logic [DIST_W-1:0]              dist_mag;
  logic signed [TOTAL_BITS:0]     tot_sum;
  logic [TIME_BITS:0]             rem_sh;
  logic [TIME_BITS+1:0]           rem_diff;
  logic                           rem_ge;
  logic [DIST_W-1:0]              quo_next;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_SAT;
      ST_SAT: state_next = ST_TOT;
      ST_TOT: begin
        if (pz) begin
          state_next = (wheel == WHEEL_RIGHT) ? ST_DONE : ST_MUL;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = (wheel == WHEEL_RIGHT) ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    in_take   = (state == ST_IDLE) && in_valid;
    out_load  = (state == ST_DONE) && (!out_valid || !out_stall);
    div_last  = (state == ST_DIV) && (cnt == DIV_LAST);
    wheel_end = ((state == ST_TOT) && pz) || div_last;
  end

  // Shared multiplier: the selected wheel's delta times its scale.
  assign mul_a     = delta[wheel];
  assign mul_b     = (wheel == WHEEL_RIGHT) ? right_scale : left_scale;
  assign prod_full = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

  // The product fits the distance range when all bits from the sign of the range up agree.
  assign prod_ones  = &prod[PROD_W-1:DIST_W-1];
  assign prod_zeros = ~|prod[PROD_W-1:DIST_W-1];

  // Total update with saturation at the signed limits.
  assign dist_cur = distance[wheel];
  assign dist_mag = dist_cur[DIST_W-1] ? DIST_W'(-dist_cur) : DIST_W'(dist_cur);
  assign tot_sum  = (TOTAL_BITS+1)'(total[wheel]) + (TOTAL_BITS+1)'(dist_cur);

  // One restoring division step on the distance magnitude.
  assign rem_sh   = {rem, quo[DIST_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, period};
  assign rem_ge   = !rem_diff[TIME_BITS+1];
  assign quo_next = {quo[DIST_W-2:0], rem_ge};

  // Sequencer and history registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      left_scale  <= LEFT_SCALE_RST;
      right_scale <= RIGHT_SCALE_RST;
      prev_left   <= '0;
      prev_right  <= '0;
      prev_time   <= '0;
      total[0]    <= '0;
      total[1]    <= '0;
      wheel       <= WHEEL_LEFT;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // Scale registers; the user must write them only while the block is idle; the block does not enforce it.
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LEFT_SCALE:  left_scale  <= cfg_data;
          REG_RIGHT_SCALE: right_scale <= cfg_data;
          default: ;
        endcase
      end

      // The sample becomes the new reference point when it is accepted.
      if (in_take) begin
        prev_left  <= left_count;
        prev_right <= right_count;
        prev_time  <= timestamp_us;
        wheel      <= WHEEL_LEFT;
      end

      if (state == ST_TOT) begin
        if (tot_sum[TOTAL_BITS] != tot_sum[TOTAL_BITS-1]) begin
          total[wheel] <= tot_sum[TOTAL_BITS] ? TOT_MIN : TOT_MAX;
        end else begin
          total[wheel] <= tot_sum[TOTAL_BITS-1:0];
        end
        cnt <= '0;
      end

      if (state == ST_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end

      if (wheel_end) begin
        wheel <= ~wheel;
      end

      // Output register handshake.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the arithmetic unit.
  always_ff @(posedge clk) begin
    if (in_take) begin
      delta[0] <= $signed(left_count - prev_left);
      delta[1] <= $signed(right_count - prev_right);
      period   <= timestamp_us - prev_time;
      pz       <= (timestamp_us == prev_time);
    end

    if (state == ST_MUL) begin
      prod <= prod_full;
    end

    if (state == ST_SAT) begin
      if (prod_ones || prod_zeros) begin
        distance[wheel] <= prod[DIST_W-1:0];
      end else begin
        distance[wheel] <= prod[PROD_W-1] ? DIST_MIN : DIST_MAX;
      end
    end

    // Load the divider with the distance magnitude.
    if (state == ST_TOT) begin
      quo     <= dist_mag;
      rem     <= '0;
      div_neg <= dist_cur[DIST_W-1];
      if (pz) begin
        speed[wheel] <= '0;
      end
    end

    if (state == ST_DIV) begin
      quo <= quo_next;
      rem <= rem_ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
      if (div_last) begin
        speed[wheel] <= div_neg ? -$signed(quo_next) : $signed(quo_next);
      end
    end

    // Result item into the output register.
    if (out_load) begin
      left_distance_nm  <= distance[0];
      right_distance_nm <= distance[1];
      left_speed_mm_s   <= speed[0];
      right_speed_mm_s  <= speed[1];
      left_total_nm     <= TOTAL_OUT_W'(total[0]);
      right_total_nm    <= TOTAL_OUT_W'(total[1]);
      period_us         <= period;
      period_zero       <= pz;
    end
  end

endmodule

// ===== bench/odometry_checker.sv =====
// Checker for the wheel odometry unit: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module odometry_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [dweo_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dweo_pkg::SCALE_W-1:0]           cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [15:0]                            left_count,
  input  logic [15:0]                            right_count,
  input  logic [31:0]                            timestamp_us,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [dweo_pkg::DIST_W-1:0]     left_distance_nm,
  input  logic signed [dweo_pkg::DIST_W-1:0]     right_distance_nm,
  input  logic signed [dweo_pkg::DIST_W-1:0]     left_speed_mm_s,
  input  logic signed [dweo_pkg::DIST_W-1:0]     right_speed_mm_s,
  input  logic signed [dweo_pkg::TOTAL_OUT_W-1:0] left_total_nm,
  input  logic signed [dweo_pkg::TOTAL_OUT_W-1:0] right_total_nm,
  input  logic [31:0]                            period_us,
  input  logic                                   period_zero,
  output int                                     failures,
  output int                                     outstanding,
  output int                                     results_checked
);
  import dweo_pkg::*;

  // One odometry reading as the block presents it.
  typedef struct packed {
    logic signed [DIST_W-1:0]      left_dist;
    logic signed [DIST_W-1:0]      right_dist;
    logic signed [DIST_W-1:0]      left_speed;
    logic signed [DIST_W-1:0]      right_speed;
    logic signed [TOTAL_OUT_W-1:0] left_total;
    logic signed [TOTAL_OUT_W-1:0] right_total;
    logic [31:0]                   period;
    logic                          zero_period;
  } odo_reading_t;

  localparam longint DIST_HI  = 64'sd34359738367;
  localparam longint DIST_LO  = -DIST_HI - 1;
  localparam longint TOTAL_HI = 64'sd140737488355327;
  localparam longint TOTAL_LO = -TOTAL_HI - 1;
  localparam int     PRINT_CAP = 50;

  // Own copy of the scales and of the odometry state.
  logic [SCALE_W-1:0] left_scale;
  logic [SCALE_W-1:0] right_scale;
  logic [15:0]        last_left;
  logic [15:0]        last_right;
  logic [31:0]        last_stamp;
  longint             left_sum;
  longint             right_sum;

  odo_reading_t pending_readings[$];
  int           mismatch_count;
  int           reading_index;

  // Signed wrapping count step times the scale, clamped to the distance range.
  function automatic longint wheel_travel(input logic [15:0] cur, input logic [15:0] prior,
                                          input logic [SCALE_W-1:0] scale);
    logic [15:0] step;
    longint      prod;
    step = cur - prior;
    prod = longint'($signed(step)) * longint'(scale);
    if (prod > DIST_HI) return DIST_HI;
    if (prod < DIST_LO) return DIST_LO;
    return prod;
  endfunction

  // Running total with saturation at the total limits.
  function automatic longint clamp_total(input longint sum);
    if (sum > TOTAL_HI) return TOTAL_HI;
    if (sum < TOTAL_LO) return TOTAL_LO;
    return sum;
  endfunction

  // Advances the odometry by one sample and returns the reading it gives.
  function automatic odo_reading_t advance_odometry(input logic [15:0] lc,
                                                    input logic [15:0] rc,
                                                    input logic [31:0] ts);
    odo_reading_t r;
    longint       ld;
    longint       rd;
    logic [31:0]  gap;
    gap = ts - last_stamp;
    ld  = wheel_travel(lc, last_left, left_scale);
    rd  = wheel_travel(rc, last_right, right_scale);
    r.left_dist   = DIST_W'(ld);
    r.right_dist  = DIST_W'(rd);
    r.period      = gap;
    r.zero_period = (gap == 32'd0);
    // A zero period forces both speeds to zero; division truncates toward zero.
    if (r.zero_period) begin
      r.left_speed  = '0;
      r.right_speed = '0;
    end else begin
      r.left_speed  = DIST_W'(ld / longint'(gap));
      r.right_speed = DIST_W'(rd / longint'(gap));
    end
    left_sum      = clamp_total(left_sum + ld);
    right_sum     = clamp_total(right_sum + rd);
    r.left_total  = TOTAL_OUT_W'(left_sum);
    r.right_total = TOTAL_OUT_W'(right_sum);
    last_left  = lc;
    last_right = rc;
    last_stamp = ts;
    return r;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] reading %0d: %s", $time, reading_index, msg);
  endtask

  task automatic compare_reading(input odo_reading_t got, input odo_reading_t want);
    if (got.left_dist !== want.left_dist)
      report_mismatch($sformatf("left_distance_nm %0d, expected %0d",
                                got.left_dist, want.left_dist));
    if (got.right_dist !== want.right_dist)
      report_mismatch($sformatf("right_distance_nm %0d, expected %0d",
                                got.right_dist, want.right_dist));
    if (got.left_speed !== want.left_speed)
      report_mismatch($sformatf("left_speed_mm_s %0d, expected %0d",
                                got.left_speed, want.left_speed));
    if (got.right_speed !== want.right_speed)
      report_mismatch($sformatf("right_speed_mm_s %0d, expected %0d",
                                got.right_speed, want.right_speed));
    if (got.left_total !== want.left_total)
      report_mismatch($sformatf("left_total_nm %0d, expected %0d",
                                got.left_total, want.left_total));
    if (got.right_total !== want.right_total)
      report_mismatch($sformatf("right_total_nm %0d, expected %0d",
                                got.right_total, want.right_total));
    if (got.period !== want.period)
      report_mismatch($sformatf("period_us %0d, expected %0d", got.period, want.period));
    if (got.zero_period !== want.zero_period)
      report_mismatch($sformatf("period_zero %0b, expected %0b",
                                got.zero_period, want.zero_period));
  endtask

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    odo_reading_t seen;
    if (rst) begin
      left_scale     = LEFT_SCALE_RST;
      right_scale    = RIGHT_SCALE_RST;
      last_left      = '0;
      last_right     = '0;
      last_stamp     = '0;
      left_sum       = 0;
      right_sum      = 0;
      mismatch_count = 0;
      reading_index  = 0;
      pending_readings.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LEFT_SCALE:  left_scale  = cfg_data;
          REG_RIGHT_SCALE: right_scale = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_readings.push_back(advance_odometry(left_count, right_count, timestamp_us));
      if (out_valid && !out_stall) begin
        seen = '{left_distance_nm, right_distance_nm, left_speed_mm_s, right_speed_mm_s,
                 left_total_nm, right_total_nm, period_us, period_zero};
        if (pending_readings.size() == 0)
          report_mismatch("result arrived with no sample waiting for it");
        else
          compare_reading(seen, pending_readings.pop_front());
        reading_index++;
      end
    end
    outstanding     <= pending_readings.size();
    failures        <= mismatch_count;
    results_checked <= reading_index;
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, sample stimulus, result stalls, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
  import dweo_pkg::*;

  localparam int QUIET_LIMIT    = 3000;
  localparam int RANDOM_SAMPLES = 690;
  localparam int RANDOM_PHASES  = 6;
  localparam int CLIMB_SAMPLES  = 40;
  localparam int END_PAUSE      = 200;
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [SCALE_W-1:0]      cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [15:0]             left_count;
  logic [15:0]             right_count;
  logic [31:0]             timestamp_us;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [DIST_W-1:0]      left_distance_nm;
  logic signed [DIST_W-1:0]      right_distance_nm;
  logic signed [DIST_W-1:0]      left_speed_mm_s;
  logic signed [DIST_W-1:0]      right_speed_mm_s;
  logic signed [TOTAL_OUT_W-1:0] left_total_nm;
  logic signed [TOTAL_OUT_W-1:0] right_total_nm;
  logic [31:0]             period_us;
  logic                    period_zero;

  int failures;
  int outstanding;
  int results_checked;

  // Stimulus bookkeeping.
  logic [15:0] cur_left;
  logic [15:0] cur_right;
  logic [31:0] cur_stamp;
  int          next_gap;
  bit          calm;
  int          samples_sent;
  int          zero_periods;
  int          scale_settings;
  int          stall_left;
  int          rx_wait;
  int          quiet_cycles;

  dual_wheel_encoder_odometry_unit dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .left_count        (left_count),
    .right_count       (right_count),
    .timestamp_us      (timestamp_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .left_distance_nm  (left_distance_nm),
    .right_distance_nm (right_distance_nm),
    .left_speed_mm_s   (left_speed_mm_s),
    .right_speed_mm_s  (right_speed_mm_s),
    .left_total_nm     (left_total_nm),
    .right_total_nm    (right_total_nm),
    .period_us         (period_us),
    .period_zero       (period_zero)
  );

  odometry_checker odo_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .left_count        (left_count),
    .right_count       (right_count),
    .timestamp_us      (timestamp_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .left_distance_nm  (left_distance_nm),
    .right_distance_nm (right_distance_nm),
    .left_speed_mm_s   (left_speed_mm_s),
    .right_speed_mm_s  (right_speed_mm_s),
    .left_total_nm     (left_total_nm),
    .right_total_nm    (right_total_nm),
    .period_us         (period_us),
    .period_zero       (period_zero),
    .failures          (failures),
    .outstanding       (outstanding),
    .results_checked   (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: each result is held off for a drawn number of cycles once it is shown.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      rx_wait = calm ? 0 : $urandom_range(16, 0);
      stall_left <= rx_wait;
      out_stall  <= (rx_wait != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Watchdog: ends the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one sample after the drawn gap and returns at the edge that accepts it.
  // Valid stays high only when the next sample follows without a gap.
  task automatic send_sample(input logic [15:0] lc, input logic [15:0] rc,
                             input logic [31:0] ts);
    repeat (next_gap) @(posedge clk);
    in_valid     <= 1'b1;
    left_count   <= lc;
    right_count  <= rc;
    timestamp_us <= ts;
    do @(posedge clk); while (in_stall);
    if (ts == cur_stamp) zero_periods++;
    cur_left  = lc;
    cur_right = rc;
    cur_stamp = ts;
    samples_sent++;
    next_gap = calm ? 0 : $urandom_range(16, 0);
    if (next_gap != 0) in_valid <= 1'b0;
  endtask

  // Moves both counters and the clock by signed steps from the last sample.
  task automatic step_by(input int dl, input int dr, input int dt);
    send_sample(cur_left + 16'(dl), cur_right + 16'(dr), cur_stamp + 32'(dt));
  endtask

  // Lowers valid and waits until every expected result has been taken.
  task automatic wait_idle;
    if (next_gap == 0) in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_scales(input logic [SCALE_W-1:0] ls, input logic [SCALE_W-1:0] rs);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LEFT_SCALE;
    cfg_data  <= ls;
    @(posedge clk);
    cfg_index <= REG_RIGHT_SCALE;
    cfg_data  <= rs;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_settings++;
  endtask

  // One random sample; mostly realistic small motion, with wraps, zero periods and noise.
  task automatic random_sample;
    int kind;
    kind = $urandom_range(9, 0);
    if (kind <= 5)
      step_by(int'($urandom_range(600, 0)) - 300, int'($urandom_range(600, 0)) - 300,
              int'($urandom_range(2000, 1)));
    else if (kind == 6)
      step_by(int'($urandom_range(65535, 0)), int'($urandom_range(65535, 0)),
              int'($urandom()));
    else if (kind == 7)
      step_by(int'($urandom_range(64, 0)) - 32, int'($urandom_range(64, 0)) - 32, 0);
    else if (kind == 8)
      step_by($urandom_range(1, 0) ? 32767 : -32768, $urandom_range(1, 0) ? 32767 : -32768,
              int'($urandom_range(3, 1)));
    else
      send_sample(16'($urandom()), 16'($urandom()), $urandom());
  endtask

  initial begin
    logic [SCALE_W-1:0] ls;
    logic [SCALE_W-1:0] rs;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_LEFT_SCALE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    left_count   = '0;
    right_count  = '0;
    timestamp_us = '0;
    cur_left     = '0;
    cur_right    = '0;
    cur_stamp    = '0;
    next_gap     = 0;
    calm         = 1'b0;
    samples_sent   = 0;
    zero_periods   = 0;
    scale_settings = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed samples with the reset scales: first sample, extreme steps, wraps,
    // zero periods and truncation of negative and positive speeds.
    step_by(0, 0, 0);
    step_by(1, -1, 1);
    step_by(32767, 32767, 0);
    step_by(-32768, -32768, 1000);
    step_by(-1, 1, -2);
    send_sample(16'hFFFA, 16'h0003, 32'hFFFF_FFF0);
    step_by(10, -10, 32'h20);
    step_by(7, 2, 3);
    step_by(-7, -2, 3);
    send_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_sample(16'h0000, 16'h0000, 32'h0000_0000);

    // Zero scales give zero distance whatever the motion.
    wait_idle();
    write_scales('0, '0);
    step_by(12345, -23456, 5);
    step_by(-1, 1, 0);

    // Largest scales with the largest steps, over the shortest period.
    wait_idle();
    write_scales(SCALE_MAX, SCALE_MAX);
    step_by(32767, -32768, 1);
    step_by(-32768, 32767, 1);
    step_by(32767, -32768, 0);
    step_by(100, -100, 7);

    // Random phases, each under its own pair of scales.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin ls = SCALE_W'($urandom()); rs = SCALE_W'($urandom()); end
        1: begin ls = SCALE_MAX;            rs = '0;                   end
        2: begin ls = '0;                   rs = SCALE_MAX;            end
        3: begin ls = SCALE_W'(1);          rs = SCALE_W'(1);          end
        4: begin ls = SCALE_W'($urandom()); rs = SCALE_MAX;            end
        default: begin ls = LEFT_SCALE_RST; rs = RIGHT_SCALE_RST;      end
      endcase
      wait_idle();
      write_scales(ls, rs);
      for (int i = 0; i < RANDOM_SAMPLES / RANDOM_PHASES; i++) begin
        if (i % 20 == 0) calm = ($urandom_range(3, 0) == 0);
        random_sample();
      end
    end

    // Push the left total hard upwards and the right one hard downwards with the
    // largest steps, then step back the other way.
    wait_idle();
    write_scales(SCALE_MAX, SCALE_MAX);
    for (int i = 0; i < CLIMB_SAMPLES; i++) begin
      if (i % 200 == 0) calm = ($urandom_range(2, 0) == 0);
      step_by(32767, -32768, 0);
    end
    calm = 1'b0;
    for (int i = 0; i < 4; i++) step_by(-32768, 32767, 1);
    for (int i = 0; i < 10; i++) random_sample();

    // Drain, then watch a while longer for any stray result.
    wait_idle();
    repeat (END_PAUSE) @(posedge clk);

    $display("Run covered %0d samples (%0d with zero period) under %0d scale settings,",
             samples_sent, zero_periods, scale_settings);
    $display("%0d results checked, including runs of the largest steps in both directions.",
             results_checked);
    if (failures == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
